// ===== sv/rlse_pkg.sv =====
package rlse_pkg;

  localparam int DEPTH_DEF = 16;

  // Operation codes carried in the kind field
  localparam logic [2:0] K_PUSH_FRONT = 3'd0;
  localparam logic [2:0] K_PUSH_BACK  = 3'd1;
  localparam logic [2:0] K_REMOVE     = 3'd2;
  localparam logic [2:0] K_SORT       = 3'd3;
  localparam logic [2:0] K_DUMP       = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] mass;
    logic [3:0]  cls;
    logic [13:0] un;
  } rec_t;

  // Port strobes of the record memory
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ===== sv/rlse_if.sv =====
interface rlse_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] rec_id_in;
  logic [15:0] mass_in;
  logic [3:0]  class_in;
  logic [13:0] un_in;

  modport source (output valid, kind, rec_id_in, mass_in, class_in, un_in, input ready);
  modport sink   (input valid, kind, rec_id_in, mass_in, class_in, un_in, output ready);
endinterface

interface rlse_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  count;
  logic [15:0] rec_id_out;
  logic [15:0] mass_out;
  logic [3:0]  class_out;
  logic [13:0] un_out;
  logic        last;

  modport source (output valid, status, count, rec_id_out, mass_out, class_out, un_out, last,
                  input ready);
  modport sink   (input valid, status, count, rec_id_out, mass_out, class_out, un_out, last,
                  output ready);
endinterface

// ===== sv/rlse_mem.sv =====
module rlse_mem import rlse_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] raddr,
  input  rec_t          wdata,
  output rec_t          rdata
);

  rec_t mem [DEPTH];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rlse_seq.sv =====
module rlse_seq import rlse_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_kind,
  input  rec_t          in_rec,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [4:0]    out_count,
  output rec_t          out_rec,
  output logic          out_last,
  output mem_ctl_t      mem_ctl,
  output logic [AW-1:0] mem_waddr,
  output logic [AW-1:0] mem_raddr,
  output rec_t          mem_wdata,
  input  rec_t          mem_rdata
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SHIFT   = 4'd1;
  localparam logic [3:0] S_PF_HEAD = 4'd2;
  localparam logic [3:0] S_SEARCH  = 4'd3;
  localparam logic [3:0] S_REMSH   = 4'd4;
  localparam logic [3:0] S_SORT_A  = 4'd5;
  localparam logic [3:0] S_SORT_B  = 4'd6;
  localparam logic [3:0] S_SORT_W  = 4'd7;
  localparam logic [3:0] S_DUMP    = 4'd8;
  localparam logic [3:0] S_RESP    = 4'd9;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] b_r, b_nxt;
  rec_t          hold_r, hold_nxt;
  rec_t          nrec_r, nrec_nxt;
  logic [1:0]    status_r, status_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [4:0]    out_count_r, out_count_nxt;
  rec_t          out_rec_r, out_rec_nxt;
  logic          out_last_r, out_last_nxt;

  logic          out_free;
  logic [CW-1:0] last_idx, i_p1, i_p2, i_m1, i_m2, b_p1;

  assign out_free = !out_valid_r || out_ready;
  assign last_idx = cnt_r - ONE_C;
  assign i_p1     = i_r + ONE_C;
  assign i_p2     = i_r + TWO_C;
  assign i_m1     = i_r - ONE_C;
  assign i_m2     = i_r - TWO_C;
  assign b_p1     = b_r + ONE_C;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    b_nxt          = b_r;
    hold_nxt       = hold_r;
    nrec_nxt       = nrec_r;
    status_nxt     = status_r;
    mem_ctl        = '0;
    mem_waddr      = '0;
    mem_raddr      = '0;
    mem_wdata      = nrec_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_rec_nxt    = out_rec_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          nrec_nxt   = in_rec;
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
          unique case (in_kind)
            K_PUSH_FRONT: begin
              if (cnt_r == DEPTH_C) begin
                status_nxt = ST_FULL;
              end else if (cnt_r == '0) begin
                state_nxt = S_PF_HEAD;
              end else begin
                // move the tail up one slot, last record first
                mem_ctl.re = 1'b1;
                mem_raddr  = last_idx[AW-1:0];
                i_nxt      = cnt_r;
                state_nxt  = S_SHIFT;
              end
            end
            K_PUSH_BACK: begin
              if (cnt_r == DEPTH_C) begin
                status_nxt = ST_FULL;
              end else begin
                mem_ctl.we = 1'b1;
                mem_waddr  = cnt_r[AW-1:0];
                mem_wdata  = in_rec;
                cnt_nxt    = cnt_r + ONE_C;
              end
            end
            K_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_NOTFOUND;
              end else begin
                mem_ctl.re = 1'b1;
                i_nxt      = '0;
                state_nxt  = S_SEARCH;
              end
            end
            K_SORT: begin
              if (cnt_r >= TWO_C) begin
                mem_ctl.re = 1'b1;
                i_nxt      = '0;
                state_nxt  = S_SORT_A;
              end
            end
            K_DUMP: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_ctl.re = 1'b1;
                i_nxt      = '0;
                state_nxt  = S_DUMP;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_SHIFT: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = i_r[AW-1:0];
        mem_wdata  = mem_rdata;
        if (i_r == ONE_C) begin
          state_nxt = S_PF_HEAD;
        end else begin
          mem_ctl.re = 1'b1;
          mem_raddr  = i_m2[AW-1:0];
          i_nxt      = i_m1;
        end
      end

      S_PF_HEAD: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = nrec_r;
        cnt_nxt    = cnt_r + ONE_C;
        state_nxt  = S_RESP;
      end

      S_SEARCH: begin
        if (mem_rdata.id == nrec_r.id) begin
          if (i_r == last_idx) begin
            cnt_nxt   = last_idx;
            state_nxt = S_RESP;
          end else begin
            // close the gap: pull each later record down one slot
            mem_ctl.re = 1'b1;
            mem_raddr  = i_p1[AW-1:0];
            state_nxt  = S_REMSH;
          end
        end else if (i_r == last_idx) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_RESP;
        end else begin
          mem_ctl.re = 1'b1;
          mem_raddr  = i_p1[AW-1:0];
          i_nxt      = i_p1;
        end
      end

      S_REMSH: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = i_r[AW-1:0];
        mem_wdata  = mem_rdata;
        if (i_p2 == cnt_r) begin
          cnt_nxt   = last_idx;
          state_nxt = S_RESP;
        end else begin
          mem_ctl.re = 1'b1;
          mem_raddr  = i_p2[AW-1:0];
          i_nxt      = i_p1;
        end
      end

      S_SORT_A: begin
        // hold record i in a register for the inner pass
        hold_nxt   = mem_rdata;
        b_nxt      = i_p1;
        mem_ctl.re = 1'b1;
        mem_raddr  = i_p1[AW-1:0];
        state_nxt  = S_SORT_B;
      end

      S_SORT_B: begin
        if (hold_r.id > mem_rdata.id) begin
          mem_ctl.we = 1'b1;
          mem_waddr  = b_r[AW-1:0];
          mem_wdata  = hold_r;
          hold_nxt   = mem_rdata;
        end
        if (b_r == last_idx) begin
          state_nxt = S_SORT_W;
        end else begin
          mem_ctl.re = 1'b1;
          mem_raddr  = b_p1[AW-1:0];
          b_nxt      = b_p1;
        end
      end

      S_SORT_W: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = i_r[AW-1:0];
        mem_wdata  = hold_r;
        if (i_p2 == cnt_r) begin
          state_nxt = S_RESP;
        end else begin
          mem_ctl.re = 1'b1;
          mem_raddr  = i_p1[AW-1:0];
          i_nxt      = i_p1;
          state_nxt  = S_SORT_A;
        end
      end

      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_count_nxt  = 5'(cnt_r);
          out_rec_nxt    = mem_rdata;
          out_last_nxt   = (i_r == last_idx);
          if (i_r == last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            mem_ctl.re = 1'b1;
            mem_raddr  = i_p1[AW-1:0];
            i_nxt      = i_p1;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = 5'(cnt_r);
          out_rec_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r          <= i_nxt;
    b_r          <= b_nxt;
    hold_r       <= hold_nxt;
    nrec_r       <= nrec_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_rec_r    <= out_rec_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign out_rec    = out_rec_r;
  assign out_last   = out_last_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("record count above depth");

  a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.we && mem_ctl.re |-> mem_waddr != mem_raddr)
    else $error("read and write of the same entry in one cycle");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.we |-> int'(mem_waddr) < DEPTH)
    else $error("write beyond the record store");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");
`endif

endmodule

// ===== sv/record_list_sort_engine.sv =====
// Channel  Dir  Handshake          Beat contents
// in_ch    in   valid/ready        kind, rec_id_in, mass_in, class_in, un_in
// out_ch   out  valid/ready        status, count, rec_id_out, mass_out, class_out, un_out, last
//
// One operation at a time; the next beat is taken once the result is queued in the output
// register. Push back, rejected cases, the no-op kinds, and remove, sort or dump with too few
// records go straight to the response; push front, remove, sort and dump step through the list
// over the single read port of the record memory, dump one record a cycle unless out_ch stalls.
// rst_n is synchronous and empties the list; memory contents are not cleared.
// A stalled out_ch holds the result and, in a dump, the walk through the list.
module record_list_sort_engine import rlse_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input logic       clk,
  input logic       rst_n,
  rlse_in_if.sink   in_ch,
  rlse_out_if.source out_ch
);

  rec_t          in_rec;
  rec_t          out_rec;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  rec_t          mem_wdata;
  rec_t          mem_rdata;

  assign in_rec = '{id: in_ch.rec_id_in, mass: in_ch.mass_in, cls: in_ch.class_in,
                    un: in_ch.un_in};

  rlse_seq #(.DEPTH(DEPTH)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_kind    (in_ch.kind),
    .in_rec     (in_rec),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_count  (out_ch.count),
    .out_rec    (out_rec),
    .out_last   (out_ch.last),
    .mem_ctl    (mem_ctl),
    .mem_waddr  (mem_waddr),
    .mem_raddr  (mem_raddr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  rlse_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .raddr (mem_raddr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign out_ch.rec_id_out = out_rec.id;
  assign out_ch.mass_out   = out_rec.mass;
  assign out_ch.class_out  = out_rec.cls;
  assign out_ch.un_out     = out_rec.un;

endmodule
